### rtl/core/khr_pkg.sv
// Package for the key hold/repeat event block: request and event types,
// event codes, register indexes and event buffer sizes.
// No dependencies; used by every module in rtl/core.
package khr_pkg;

    // Event codes carried in each output request.
    typedef enum logic [1:0] {
        EV_PRESS  = 2'd0,
        EV_SHORT  = 2'd1,
        EV_HOLD   = 2'd2,
        EV_REPEAT = 2'd3
    } t_event_code;

    // Configuration register indexes.
    localparam logic REG_REPEAT_SPEED = 1'b0;
    localparam logic REG_HOLD_TIME    = 1'b1;

    localparam logic [7:0] HOLD_TIME_RESET    = 8'd25;
    localparam logic [7:0] REPEAT_SPEED_RESET = 8'd0;

    // Number of keys, events one key can raise per scan, and buffer sizing.
    localparam int NUM_KEYS       = 2;
    localparam int LANE_MAX_EV    = 2;
    localparam int SCAN_MAX_EV    = NUM_KEYS * LANE_MAX_EV;
    localparam int EVQ_DEPTH      = 8;
    localparam int EVQ_PTR_W      = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W      = $clog2(EVQ_DEPTH + 1);

    // One scan sample of both keys (active low levels).
    typedef struct packed {
        logic up_level;
        logic down_level;
    } t_in_item;

    // One event request.
    typedef struct packed {
        t_event_code event_code;
        logic        key_index;
        logic        last_event;
    } t_out_item;

    // Configuration as seen by each key lane. The load value is the repeat
    // speed being written in this cycle.
    typedef struct packed {
        logic [7:0] repeat_speed;
        logic [7:0] hold_time;
        logic       load_repeat;
        logic [7:0] load_value;
    } t_lane_cfg;

    // Events found by one key lane for one scan, in order.
    typedef struct packed {
        logic [1:0]                        cnt;
        t_event_code [LANE_MAX_EV-1:0]     codes;
    } t_lane_ev;

endpackage

### rtl/core/khr_lane.sv
// One key lane: hold and repeat countdowns of a single key and the
// events that one scan sample of that key raises. Depends on khr_pkg.
module khr_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_released,
    input  khr_pkg::t_lane_cfg i_cfg,
    output khr_pkg::t_lane_ev  o_ev
);
    import khr_pkg::*;

    logic [7:0] r_hold;
    logic [7:0] n_hold;
    logic [7:0] r_repeat;
    logic [7:0] n_repeat;

    logic [7:0] hold_m1;
    logic       rep_on;
    logic       ev_short;
    logic       ev_press;
    logic       ev_hold;
    logic       ev_rep_hold;
    logic       ev_rep_cycle;

    assign hold_m1 = i_cfg.hold_time - 8'd1;
    assign rep_on  = (i_cfg.repeat_speed != 8'd0);

    // Decide the events of this sample and the next countdown values.
    always_comb begin
        ev_short     = 1'b0;
        ev_press     = 1'b0;
        ev_hold      = 1'b0;
        ev_rep_hold  = 1'b0;
        ev_rep_cycle = 1'b0;
        n_hold       = r_hold;
        n_repeat     = r_repeat;
        if (i_released) begin
            ev_short = (r_hold != i_cfg.hold_time) && (r_hold != 8'd0);
            n_hold   = i_cfg.hold_time;
            n_repeat = i_cfg.repeat_speed;
        end else begin
            ev_press    = (r_hold == hold_m1);
            ev_hold     = !ev_press && (r_hold == 8'd1);
            ev_rep_hold = ev_hold && rep_on;
            if (r_hold != 8'd0) begin
                n_hold = r_hold - 8'd1;
            end else if (rep_on) begin
                if (r_repeat == 8'd0) begin
                    ev_rep_cycle = 1'b1;
                    n_repeat     = i_cfg.repeat_speed;
                end else begin
                    n_repeat = r_repeat - 8'd1;
                end
            end
        end
    end

    // Pack the events in the order they occur.
    always_comb begin
        logic [1:0] n;
        n = 2'd0;
        o_ev.codes = {LANE_MAX_EV{EV_PRESS}};
        if (ev_short) begin
            o_ev.codes[n[0]] = EV_SHORT;
            n = n + 2'd1;
        end
        if (ev_press) begin
            o_ev.codes[n[0]] = EV_PRESS;
            n = n + 2'd1;
        end
        if (ev_rep_hold) begin
            o_ev.codes[n[0]] = EV_REPEAT;
            n = n + 2'd1;
        end
        if (ev_hold) begin
            o_ev.codes[n[0]] = EV_HOLD;
            n = n + 2'd1;
        end
        if (ev_rep_cycle) begin
            o_ev.codes[n[0]] = EV_REPEAT;
            n = n + 2'd1;
        end
        o_ev.cnt = n;
    end

    // Countdown registers; a repeat speed write loads the new speed into the
    // repeat count when no scan is accepted in that cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= 8'd0;
            r_repeat <= 8'd0;
        end else if (i_accept) begin
            r_hold   <= n_hold;
            r_repeat <= n_repeat;
        end else if (i_cfg.load_repeat) begin
            r_repeat <= i_cfg.load_value;
        end
    end

endmodule

### rtl/core/khr_merge.sv
// Merge stage: orders the events of both key lanes, marks the last one of
// the scan and queues them for the output channel. Depends on khr_pkg.
module khr_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  khr_pkg::t_lane_ev [khr_pkg::NUM_KEYS-1:0] i_lane_ev,
    output logic                                o_room,
    output logic                                o_valid,
    input  logic                                i_ready,
    output khr_pkg::t_out_item                  o_item
);
    import khr_pkg::*;

    t_out_item               r_mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]    r_wr_ptr;
    logic [EVQ_PTR_W-1:0]    r_rd_ptr;
    logic [EVQ_CNT_W-1:0]    r_count;
    logic [EVQ_CNT_W-1:0]    n_count;

    logic [2:0]              total;
    logic                    pop;
    t_out_item [SCAN_MAX_EV-1:0] slot;

    assign total = {1'b0, i_lane_ev[0].cnt} + {1'b0, i_lane_ev[1].cnt};

    // Place up key events first, then down key events.
    always_comb begin
        logic [1:0] kk;
        logic [1:0] idx;
        for (int k = 0; k < SCAN_MAX_EV; k++) begin
            kk  = 2'(k);
            idx = kk - i_lane_ev[0].cnt;
            if (kk < i_lane_ev[0].cnt) begin
                slot[k].event_code = i_lane_ev[0].codes[kk[0]];
                slot[k].key_index  = 1'b0;
            end else begin
                slot[k].event_code = i_lane_ev[1].codes[idx[0]];
                slot[k].key_index  = 1'b1;
            end
            slot[k].last_event = ({1'b0, kk} == (total - 3'd1));
        end
    end

    assign o_room  = (r_count <= EVQ_CNT_W'(EVQ_DEPTH - SCAN_MAX_EV));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push) begin
            n_count = n_count + EVQ_CNT_W'(total);
        end
        if (pop) begin
            n_count = n_count - EVQ_CNT_W'(1);
        end
    end

    // Event queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < SCAN_MAX_EV; k++) begin
                if (3'(k) < total) begin
                    r_mem[r_wr_ptr + EVQ_PTR_W'(k)] <= slot[k];
                end
            end
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + EVQ_PTR_W'(total);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + EVQ_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

### rtl/core/key_hold_repeat_events_core.sv
// Key hold/repeat event generator for two active-low keys.
//
// Input channel: one request per scan sample (up and down key levels,
// 1 released, 0 pressed), taken on i_in_valid and o_in_ready.
// Output channel: one event request per handshake on o_out_valid and
// i_out_ready; a scan raises zero to four events, up key first, and the
// last event of a scan carries last_event set. A scan with no events
// produces no output request.
// Events of a scan enter the registered event queue when it is accepted.
// Throughput: a scan is accepted every cycle while the eight-entry event
// queue has room for four events; events drain at one per cycle while
// i_out_ready is high.
// Configuration: i_cfg_we writes register i_cfg_index (0 repeat speed,
// 1 hold time) with i_cfg_data at once; writing the repeat speed reloads
// both repeat counters unless a scan is accepted in that cycle. Write only while idle.
// Reset: both countdowns clear, repeat speed 0, hold time 25, queue empty.
// When the receiver stalls, queued events wait and o_in_ready drops once
// fewer than four entries are free.
// Depends on khr_pkg, khr_lane and khr_merge.
module key_hold_repeat_events_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  khr_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output khr_pkg::t_out_item o_out_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import khr_pkg::*;

    logic [7:0] r_repeat_speed;
    logic [7:0] r_hold_time;

    logic                          accept;
    t_lane_cfg                     lane_cfg;
    t_lane_ev [NUM_KEYS-1:0]       lane_ev;
    logic [NUM_KEYS-1:0]           released;

    assign accept   = i_in_valid && o_in_ready;
    assign released = {i_in_item.down_level, i_in_item.up_level};

    assign lane_cfg.repeat_speed = r_repeat_speed;
    assign lane_cfg.hold_time    = r_hold_time;
    assign lane_cfg.load_repeat  = i_cfg_we && (i_cfg_index == REG_REPEAT_SPEED);
    assign lane_cfg.load_value   = i_cfg_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_speed <= REPEAT_SPEED_RESET;
            r_hold_time    <= HOLD_TIME_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_REPEAT_SPEED) begin
                r_repeat_speed <= i_cfg_data;
            end else begin
                r_hold_time <= i_cfg_data;
            end
        end
    end

    // One lane per key.
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        khr_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_accept   (accept),
            .i_released (released[g]),
            .i_cfg      (lane_cfg),
            .o_ev       (lane_ev[g])
        );
    end

    // Merge lane events into the output queue.
    khr_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (accept),
        .i_lane_ev (lane_ev),
        .o_room    (o_in_ready),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

endmodule
